### rtl/huffman_code_table_encoder_defines.svh
// Assertion macros for the Huffman code table encoder checker.
`ifndef HUFFMAN_CODE_TABLE_ENCODER_DEFINES_SVH
`define HUFFMAN_CODE_TABLE_ENCODER_DEFINES_SVH

// Same-cycle implication, checked through reset.
`define HCTE_ASSERT_SAME(lbl, clk, a, c) \
  lbl: assert property (@(posedge clk) (a) |-> (c)) \
    else $error("hcte same-cycle check failed");

// Next-cycle implication, off while reset is high.
`define HCTE_ASSERT_NEXT(lbl, clk, rst, a, c) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("hcte next-cycle check failed");

`endif

### rtl/hcte_pkg.sv
// Package with the constants and types of the Huffman code table encoder.
package hcte_pkg;

  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;

  localparam int SYM_W   = 8;
  localparam int WORD_W  = 32;
  localparam int LEN_W   = 6;
  localparam int OP_W    = 2;
  localparam int BYTE_W  = 8;
  localparam int IN_W    = 48;
  localparam int ENTRY_W = WORD_W + LEN_W;
  localparam int ADDR_W  = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
  localparam int PEND_W  = BYTE_W - 1;
  localparam int ACC_W   = MAX_CODE_LEN + PEND_W;
  localparam int TOT_W   = $clog2(ACC_W + 1);

  typedef enum logic [OP_W-1:0] {
    OP_WRITE  = 2'd0,
    OP_ENCODE = 2'd1,
    OP_FLUSH  = 2'd2
  } op_t;

endpackage

### rtl/hcte_ram.sv
// Generic single-write, single-read RAM with registered read data.
module hcte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/huffman_code_table_encoder.sv
// Top level of the Huffman code table encoder with MSB-first byte packer.
//
// Input words arrive on s_axis: tuser carries the op (write table entry,
// encode symbol, flush). A write stores code word and saturated length in
// the code table RAM; an encode reads the table and appends the code to
// the pending bits; a flush pads pending bits with zeros and sends them.
// Output words leave on m_axis, one packed byte per word, earliest bit in
// bit 7, tlast high on the last byte caused by one input word.
// Path: an encode passes the table lookup stage (s1), the packer's
// accumulator and the output register; a flush skips the accumulator.
// The byte packer sets the throughput: while it holds a full byte it
// emits bytes and takes no new word from s1; a table write does not
// occupy it. Table lookup and packing overlap, so a new word is taken
// while earlier bytes are still leaving.
// Reset clears the table valid bits (every entry reads as length zero),
// the pending bits and all handshake state.
// When m_axis stalls, the output register holds its byte, the packer and
// the lookup stage back up, and s_axis_tready drops.
module huffman_code_table_encoder (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // symbol [7:0], code_word [39:8], code_length [45:40], zero [47:46]
  input  logic [hcte_pkg::IN_W-1:0]  s_axis_tdata,
  // op [1:0]
  input  logic [hcte_pkg::OP_W-1:0]  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // out_byte [7:0]
  output logic [hcte_pkg::BYTE_W-1:0] m_axis_tdata,
  output logic                       m_axis_tlast
);

  localparam int AW = hcte_pkg::ADDR_W;
  localparam int LW = hcte_pkg::LEN_W;
  localparam int WW = hcte_pkg::WORD_W;
  localparam int TW = hcte_pkg::TOT_W;
  localparam int CW = hcte_pkg::ACC_W;
  localparam int PW = hcte_pkg::PEND_W;
  localparam int BW = hcte_pkg::BYTE_W;

  hcte_pkg::op_t              in_op;
  logic [hcte_pkg::SYM_W-1:0] in_sym;
  logic [WW-1:0]              in_word;
  logic [LW-1:0]              in_len;
  logic [LW-1:0]              len_sat;
  logic                       sym_ok;
  logic                       accept;
  logic                       tbl_we;
  logic                       tbl_re;
  logic [hcte_pkg::ENTRY_W-1:0] tbl_rdata;
  logic                       tbl_valid [hcte_pkg::SYMBOL_COUNT];
  logic                       ent_vld;

  logic                       s1_valid;
  logic                       s1_flush;
  logic                       s1_take;

  logic [CW-1:0]              acc;
  logic [CW-1:0]              acc_next;
  logic [TW-1:0]              total;
  logic [TW-1:0]              total_next;
  logic                       busy;
  logic                       out_free;
  logic                       emit;
  logic [BW-1:0]              emit_data;
  logic                       emit_last;

  logic [LW-1:0]              ent_len;
  logic [WW-1:0]              ent_word;
  logic [WW:0]                code_mask;
  logic [WW-1:0]              code;
  logic [PW:0]                pend_mask;
  logic [PW-1:0]              pend;
  logic [CW-1:0]              acc_load;
  logic [TW-1:0]              tot_load;
  logic [TW-1:0]              tot_rem;
  logic [BW-1:0]              byte_sel;
  logic [BW-1:0]              flush_byte;

  assign in_op   = hcte_pkg::op_t'(s_axis_tuser);
  assign in_sym  = s_axis_tdata[7:0];
  assign in_word = s_axis_tdata[39:8];
  assign in_len  = s_axis_tdata[45:40];

  assign len_sat = (in_len > LW'(hcte_pkg::MAX_CODE_LEN)) ?
                   LW'(hcte_pkg::MAX_CODE_LEN) : in_len;
  assign sym_ok  = {1'b0, in_sym} < 9'(hcte_pkg::SYMBOL_COUNT);

  assign accept = s_axis_tvalid && s_axis_tready;
  assign tbl_we = accept && (in_op == hcte_pkg::OP_WRITE) && sym_ok;
  assign tbl_re = accept && (in_op == hcte_pkg::OP_ENCODE);

  hcte_ram #(
    .WIDTH (hcte_pkg::ENTRY_W),
    .DEPTH (hcte_pkg::SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (in_sym[AW-1:0]),
    .wdata ({len_sat, in_word}),
    .re    (tbl_re),
    .raddr (in_sym[AW-1:0]),
    .rdata (tbl_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < hcte_pkg::SYMBOL_COUNT; i++) begin
        tbl_valid[i] <= 1'b0;
      end
    end else if (tbl_we) begin
      tbl_valid[in_sym[AW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (tbl_re) begin
      ent_vld <= sym_ok && tbl_valid[in_sym[AW-1:0]];
    end
  end

  assign s_axis_tready = !s1_valid || s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_axis_tready) begin
      s1_valid <= accept &&
                  ((in_op == hcte_pkg::OP_ENCODE) || (in_op == hcte_pkg::OP_FLUSH));
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_flush <= (in_op == hcte_pkg::OP_FLUSH);
    end
  end

  assign ent_len   = ent_vld ? tbl_rdata[WW +: LW] : '0;
  assign ent_word  = ent_vld ? tbl_rdata[WW-1:0] : '0;
  assign code_mask = ((WW+1)'(1) << ent_len) - (WW+1)'(1);
  assign code      = ent_word & code_mask[WW-1:0];
  assign pend_mask = ((PW+1)'(1) << total[2:0]) - (PW+1)'(1);
  assign pend      = acc[PW-1:0] & pend_mask[PW-1:0];
  assign acc_load  = (CW'(pend) << ent_len) | CW'(code);
  assign tot_load  = total + TW'(ent_len);
  assign tot_rem   = total - TW'(BW);
  assign byte_sel  = BW'(acc >> tot_rem);
  assign flush_byte = BW'({1'b0, pend} << (4'(BW) - {1'b0, total[2:0]}));

  assign busy     = total >= TW'(BW);
  assign out_free = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    acc_next   = acc;
    total_next = total;
    s1_take    = 1'b0;
    emit       = 1'b0;
    emit_data  = byte_sel;
    emit_last  = 1'b0;
    priority if (busy) begin
      if (out_free) begin
        emit       = 1'b1;
        emit_last  = tot_rem < TW'(BW);
        total_next = tot_rem;
      end
    end else if (s1_valid && !s1_flush) begin
      s1_take    = 1'b1;
      acc_next   = acc_load;
      total_next = tot_load;
    end else if (s1_valid && (total == '0)) begin
      s1_take = 1'b1;
    end else if (s1_valid && out_free) begin
      s1_take    = 1'b1;
      emit       = 1'b1;
      emit_data  = flush_byte;
      emit_last  = 1'b1;
      total_next = '0;
    end else begin
      s1_take = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else begin
      total <= total_next;
    end
  end

  always_ff @(posedge clk) begin
    acc <= acc_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_axis_tdata <= emit_data;
      m_axis_tlast <= emit_last;
    end
  end

endmodule

### rtl/hcte_checker.sv
// Port checker for the Huffman code table encoder, bound to the top level.
`include "huffman_code_table_encoder_defines.svh"

module hcte_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        s_axis_tready,
  input logic                        m_axis_tvalid,
  input logic                        m_axis_tready,
  input logic [hcte_pkg::BYTE_W-1:0] m_axis_tdata,
  input logic                        m_axis_tlast
);

  logic                      out_stall;
  logic [hcte_pkg::BYTE_W:0] out_word;

  assign out_stall = m_axis_tvalid && !m_axis_tready;
  assign out_word  = {m_axis_tlast, m_axis_tdata};

  `HCTE_ASSERT_NEXT(a_out_hold, clk, rst, out_stall, m_axis_tvalid && $stable(out_word))
  `HCTE_ASSERT_SAME(a_rst_out_idle, clk, $past(rst), !m_axis_tvalid)
  `HCTE_ASSERT_SAME(a_rst_in_ready, clk, $past(rst), s_axis_tready)

endmodule

bind huffman_code_table_encoder hcte_checker u_hcte_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
